// ----- design/nlmt_pkg.sv -----
// Package for the nearest line map table.
// Holds the table sizes, action and status codes and the sequencer states.
// No dependencies.
package nlmt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int LINE_BITS   = 19;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

  typedef logic [LINE_BITS-1:0] line_t;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_FWD = 2'd1;
  localparam logic [1:0] ACT_REV = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

// ----- design/nearest_line_map_table.sv -----
// Nearest line map table: stores (source, generated) line pairs and answers
// nearest-value queries in either direction by a linear scan.
// Depends on nlmt_pkg.
//
// Usage. An item is transferred when start is high and busy is low. Its
// action selects an add (store the pair), a forward query (nearest source
// line, answer its generated line) or a reverse query (nearest generated
// line, answer its source line). Every item gives exactly one result on
// out_status and out_answer_line, shown for a single cycle with out_valid.
// The receiver cannot stall, so results are never held back.
// Adds, queries on an empty table and unused actions answer in the cycle
// after the transfer and leave busy low, so one such item may follow every
// cycle. A query keeps busy high while it scans the stored pairs: the
// pair memory has one read port, and one subtract-and-compare unit looks
// at one pair per cycle. The scan state reads the pairs in order and the
// drain state makes the final compare, which covers the registered memory
// read. The result appears in the cycle in which busy falls. Reset empties
// the table; pair memory contents are not cleared and are never used in a
// compare before they are written. On ties the earliest stored pair wins.
// An add to a full table drops the pair and reports full.
module nearest_line_map_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [nlmt_pkg::LINE_BITS-1:0] in_source_line,
  input  logic [nlmt_pkg::LINE_BITS-1:0] in_generated_line,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [nlmt_pkg::LINE_BITS-1:0] out_answer_line
);

  localparam int LB = nlmt_pkg::LINE_BITS;
  localparam int IB = nlmt_pkg::IDX_BITS;
  localparam int CB = nlmt_pkg::CNT_BITS;

  // Pair memory: generated line in the low half, source line in the high half.
  logic [2*LB-1:0] pair_mem [nlmt_pkg::TABLE_DEPTH];
  logic [2*LB-1:0] rdata_r;
  logic            mem_we;

  nlmt_pkg::state_t state_r, state_nxt;
  logic [CB-1:0] count_r, count_nxt;
  logic [IB-1:0] addr_r, addr_nxt;
  logic [IB-1:0] last_idx;
  logic          rvld_r, rvld_nxt;
  logic          first_r, first_nxt;
  logic          rev_r, rev_nxt;
  logic [LB-1:0] key_r, key_nxt;
  logic [LB-1:0] best_diff_r, best_diff_nxt;
  logic [LB-1:0] best_val_r, best_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [LB-1:0] out_answer_r, out_answer_nxt;

  logic [LB-1:0] cmp_key, cmp_val, diff;
  logic [LB:0]   sub;
  logic [CB-1:0] count_m1;

  assign busy            = (state_r != nlmt_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_answer_line = out_answer_r;

  assign count_m1 = count_r - CB'(1);
  assign last_idx = count_m1[IB-1:0];

  // The shared compare unit works on the pair read in the previous cycle.
  assign cmp_key = rev_r ? rdata_r[LB-1:0]    : rdata_r[2*LB-1:LB];
  assign cmp_val = rev_r ? rdata_r[2*LB-1:LB] : rdata_r[LB-1:0];
  assign sub     = {1'b0, cmp_key} - {1'b0, key_r};
  assign diff    = sub[LB] ? (key_r - cmp_key) : sub[LB-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    first_nxt      = first_r;
    rev_nxt        = rev_r;
    key_nxt        = key_r;
    best_diff_nxt  = best_diff_r;
    best_val_nxt   = best_val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_answer_nxt = out_answer_r;
    mem_we         = 1'b0;
    rvld_nxt       = (state_r == nlmt_pkg::ST_SCAN);

    if (rvld_r) begin
      first_nxt = 1'b0;
      if (first_r || (diff < best_diff_r)) begin
        best_diff_nxt = diff;
        best_val_nxt  = cmp_val;
      end
    end

    unique case (state_r)
      nlmt_pkg::ST_IDLE: begin
        if (start) begin
          out_answer_nxt = '0;
          out_status_nxt = nlmt_pkg::STS_OK;
          unique case (in_action) inside
            nlmt_pkg::ACT_ADD: begin
              out_valid_nxt = 1'b1;
              if (count_r < nlmt_pkg::DEPTH_CNT) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CB'(1);
              end else begin
                out_status_nxt = nlmt_pkg::STS_FULL;
              end
            end
            nlmt_pkg::ACT_FWD, nlmt_pkg::ACT_REV: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = nlmt_pkg::STS_EMPTY;
              end else begin
                rev_nxt   = (in_action == nlmt_pkg::ACT_REV);
                key_nxt   = (in_action == nlmt_pkg::ACT_REV) ? in_generated_line
                                                             : in_source_line;
                addr_nxt  = '0;
                first_nxt = 1'b1;
                state_nxt = nlmt_pkg::ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      nlmt_pkg::ST_SCAN: begin
        if (addr_r == last_idx) begin
          state_nxt = nlmt_pkg::ST_DRAIN;
        end else begin
          addr_nxt = addr_r + IB'(1);
        end
      end
      nlmt_pkg::ST_DRAIN: begin
        // The last pair is compared in this cycle; its outcome is the answer.
        state_nxt      = nlmt_pkg::ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = nlmt_pkg::STS_OK;
        out_answer_nxt = best_val_nxt;
      end
      default: begin
        state_nxt = nlmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlmt_pkg::ST_IDLE;
      count_r     <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    first_r      <= first_nxt;
    rev_r        <= rev_nxt;
    key_r        <= key_nxt;
    best_diff_r  <= best_diff_nxt;
    best_val_r   <= best_val_nxt;
    out_status_r <= out_status_nxt;
    out_answer_r <= out_answer_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[count_r[IB-1:0]] <= {in_source_line, in_generated_line};
    end
    rdata_r <= pair_mem[addr_r];
  end

endmodule
